// ===== src/rswa_pkg.sv =====
`timescale 1ns / 1ps

package rswa_pkg;

    typedef longint unsigned u64_t;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 512;

    // Effective width and height must hold the maximum itself.
    localparam int WIDTH_W  = $clog2(MAX_WIDTH) + 1;
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT) + 1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int KIND_W = 2;
    localparam int ADDR_W = 19;
    localparam int DIST_W = 10;
    localparam int PX_W   = 10;
    localparam int PY_W   = 9;

    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] table_address;
        logic [DIST_W-1:0] table_value;
        logic [PX_W-1:0]   pixel_x;
        logic [PY_W-1:0]   pixel_y;
    } item_t;

    typedef struct packed {
        logic [PX_W-1:0]   src_x;
        logic [PY_W-1:0]   src_y;
        logic [ADDR_W-1:0] src_address;
    } result_t;

    // Sine wave: 1024 points per period, Q15 amplitude.
    localparam int SINE_IDX_W = 10;
    localparam int QIDX_W     = 9;
    localparam int QUARTER    = 256;
    localparam int SINE_W     = 16;
    localparam int TERM_MAG_W = 6;
    localparam int TERM_W     = 7;
    localparam u64_t PI_Q30   = 64'd3373259426;

    typedef logic [QUARTER:0][14:0] qrom_t;
    typedef logic [QUARTER:0][TERM_MAG_W-1:0] term_tab_t;

    typedef struct packed {
        logic              neg;
        logic [QIDX_W-1:0] j;
    } fold_t;

    // Multiplies a Q30 term by x squared, truncating after each product.
    function automatic u64_t q30_sq_step(u64_t t, u64_t x);
        return (((t * x) >> 30) * x) >> 30;
    endfunction

    // Quarter wave from a truncated Taylor sum in Q30, scaled to Q15.
    function automatic qrom_t build_qrom();
        qrom_t   rom;
        u64_t    x;
        u64_t    t;
        u64_t    v;
        longint  s;
        for (int j = 0; j <= QUARTER; j++)
        begin
            x = (u64_t'(j) * PI_Q30) >> 9;
            t = x;
            s = longint'(x);
            // Terms up to x^17; each divisor is (2n)(2n+1) for term n.
            t = q30_sq_step(t, x) / 64'd6;
            s = s - longint'(t);
            t = q30_sq_step(t, x) / 64'd20;
            s = s + longint'(t);
            t = q30_sq_step(t, x) / 64'd42;
            s = s - longint'(t);
            t = q30_sq_step(t, x) / 64'd72;
            s = s + longint'(t);
            t = q30_sq_step(t, x) / 64'd110;
            s = s - longint'(t);
            t = q30_sq_step(t, x) / 64'd156;
            s = s + longint'(t);
            t = q30_sq_step(t, x) / 64'd210;
            s = s - longint'(t);
            t = q30_sq_step(t, x) / 64'd272;
            s = s + longint'(t);
            if (s < 0)
                s = 0;
            v = (u64_t'(s) * 32767) >> 30;
            if (v > 32767)
                v = 32767;
            rom[j] = v[14:0];
        end
        rom[0]       = '0;
        rom[QUARTER] = 15'd32767;
        return rom;
    endfunction

    localparam qrom_t QROM = build_qrom();

    // Magnitude of a frame wave term; the sign is applied later, which
    // gives truncation toward zero for both signs.
    function automatic term_tab_t build_term(qrom_t rom, int amp);
        term_tab_t tab;
        for (int j = 0; j <= QUARTER; j++)
        begin
            tab[j] = TERM_MAG_W'((int'(rom[j]) * amp) / 32767);
        end
        return tab;
    endfunction

    localparam term_tab_t TERM_A30 = build_term(QROM, 30);
    localparam term_tab_t TERM_A35 = build_term(QROM, 35);
    localparam term_tab_t TERM_A40 = build_term(QROM, 40);
    localparam term_tab_t TERM_A50 = build_term(QROM, 50);

    function automatic fold_t sine_fold(logic [SINE_IDX_W-1:0] n);
        fold_t f;
        f.neg = n[SINE_IDX_W-1];
        case (n[SINE_IDX_W-1:SINE_IDX_W-2])
            2'd0:    f.j = {1'b0, n[7:0]};
            2'd1:    f.j = QIDX_W'(10'd512 - n);
            2'd2:    f.j = {1'b0, n[7:0]};
            default: f.j = QIDX_W'(11'd1024 - {1'b0, n});
        endcase
        return f;
    endfunction

    function automatic logic signed [SINE_W-1:0] sine_value(logic [SINE_IDX_W-1:0] n);
        fold_t                     f;
        logic signed [SINE_W-1:0]  m;
        f = sine_fold(n);
        m = signed'({1'b0, QROM[f.j]});
        return f.neg ? -m : m;
    endfunction

    function automatic logic signed [TERM_W-1:0] term_value(fold_t f, term_tab_t tab,
                                                            logic amp_neg);
        logic signed [TERM_W-1:0] m;
        m = signed'({1'b0, tab[f.j]});
        return (f.neg ^ amp_neg) ? -m : m;
    endfunction

endpackage

// ===== src/rswa_if.sv =====
`timescale 1ns / 1ps

interface rswa_item_if import rswa_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rswa_result_if import rswa_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/radial_sine_warp_address.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// item      in         kind, table_address, table_value, pixel_x, pixel_y
// result    out        src_x, src_y, src_address (one beat per pixel item)
// cfg       in         cfg_we, cfg_index, cfg_data (frame_width, frame_height)
//
// One item is taken every cycle unless the pipeline stalls; a pixel result becomes
// valid once its beat has passed through stage 1, then stages 2 to 7 and the
// output register, in that order.
// The distance memory is a single-port RAM touched at most once per item, as the
// item leaves stage 2.
// Reset clears valid bits, the phase and the wave amplitudes, and sets the frame
// size to 640 by 480; the distance memory is not cleared.
// Each stage stalls only when the stage after it is full and stalled, so bubbles
// are squeezed out and the input stays ready while a result waits until the
// pipeline has filled.

module radial_sine_warp_address import rswa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    rswa_item_if.sink             item,
    rswa_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FRAME_TERMS = 5;
    localparam int TERM_XA     = 0;
    localparam int TERM_XB     = 1;
    localparam int TERM_YA     = 2;
    localparam int TERM_YB     = 3;
    localparam int TERM_C      = 4;

    localparam logic [SINE_IDX_W-1:0] XA_OFS = 10'd100;
    localparam logic [SINE_IDX_W-1:0] XB_OFS = 10'd1014;
    localparam logic [SINE_IDX_W-1:0] YB_OFS = 10'd30;
    localparam logic [SINE_IDX_W-1:0] C_OFS  = 10'd954;
    localparam logic [SINE_IDX_W-1:0] COS_OFS = 10'd256;

    // Configuration, stored already clamped to the legal frame size.
    logic [WIDTH_W-1:0]  width_reg;
    logic [WIDTH_W-1:0]  width_next;
    logic [HEIGHT_W-1:0] height_reg;
    logic [HEIGHT_W-1:0] height_next;

    logic [PY_W-1:0]     phase_reg;
    logic signed [7:0]   x_wave_reg;
    logic signed [7:0]   x_wave_next;
    logic signed [7:0]   y_wave_reg;
    logic signed [7:0]   y_wave_next;
    logic signed [6:0]   c_wave_reg;
    logic signed [6:0]   c_wave_next;

    logic [DIST_W-1:0]   dist_mem [MEM_DEPTH];

    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_out;
    logic accept;
    logic kind_ok;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic out_valid_reg;

    // Stage 1
    logic [KIND_W-1:0]     kind1_reg;
    logic [PX_W-1:0]       px1_reg;
    logic [PY_W-1:0]       py1_reg;
    logic [ADDR_W-1:0]     taddr1_reg;
    logic [DIST_W-1:0]     tval1_reg;
    logic [PY_W-1:0]       t1_reg;
    logic [19:0]           pix_prod1;
    logic [ADDR_W-1:0]     pix_addr1;
    logic [SINE_IDX_W-1:0] t1_ext;
    logic [SINE_IDX_W-1:0] xa_sum1;
    logic [SINE_IDX_W-1:0] c_sum1;
    logic [SINE_IDX_W-1:0] fidx1 [FRAME_TERMS];

    // Stage 2
    logic [KIND_W-1:0]     kind2_reg;
    logic [PX_W-1:0]       px2_reg;
    logic [PY_W-1:0]       py2_reg;
    logic [ADDR_W-1:0]     addr2_reg;
    logic [DIST_W-1:0]     tval2_reg;
    fold_t                 fold2_reg [FRAME_TERMS];

    // Stage 3
    logic [KIND_W-1:0]        kind3_reg;
    logic [PX_W-1:0]          px3_reg;
    logic [PY_W-1:0]          py3_reg;
    logic [DIST_W-1:0]        d3_reg;
    logic signed [TERM_W-1:0] term3_reg [FRAME_TERMS];
    logic signed [16:0]       cprod3;

    // Stage 4
    logic [PX_W-1:0]       px4_reg;
    logic [PY_W-1:0]       py4_reg;
    logic [QIDX_W-1:0]     ihi4_reg;
    logic signed [7:0]     xw4_reg;
    logic signed [7:0]     yw4_reg;
    logic [SINE_IDX_W-1:0] i4;

    // Stage 5
    logic [PX_W-1:0]          px5_reg;
    logic [PY_W-1:0]          py5_reg;
    logic signed [7:0]        xw5_reg;
    logic signed [7:0]        yw5_reg;
    logic signed [SINE_W-1:0] sin5_reg;
    logic signed [SINE_W-1:0] cos5_reg;
    logic signed [23:0]       xprod5;
    logic signed [23:0]       yprod5;
    logic signed [8:0]        offx5;
    logic signed [8:0]        offy5;

    // Stage 6
    logic signed [11:0] dx6_reg;
    logic signed [11:0] dy6_reg;
    logic signed [11:0] xlim6;
    logic signed [11:0] ylim6;
    logic [PX_W-1:0]    sx6;
    logic [PY_W-1:0]    sy6;

    // Stage 7 and output
    logic [PX_W-1:0]   sx7_reg;
    logic [PY_W-1:0]   sy7_reg;
    logic [19:0]       out_prod7;
    result_t           out_data_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cfg_data < CFG_DATA_W'(2))
            width_next = WIDTH_W'(2);
        else if (cfg_data > CFG_DATA_W'(MAX_WIDTH))
            width_next = WIDTH_W'(MAX_WIDTH);
        else
            width_next = WIDTH_W'(cfg_data);

        if (cfg_data[HEIGHT_W-1:0] < HEIGHT_W'(2))
            height_next = HEIGHT_W'(2);
        else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_HEIGHT))
            height_next = HEIGHT_W'(MAX_HEIGHT);
        else
            height_next = cfg_data[HEIGHT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(RESET_WIDTH);
            height_reg <= HEIGHT_W'(RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= width_next;
                CFG_FRAME_HEIGHT: height_reg <= height_next;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its item moves on.
    // ------------------------------------------------------------------
    assign ld_out = !out_valid_reg || result.ready;
    assign ld7    = !v7_reg || ld_out;
    assign ld6    = !v6_reg || ld7;
    assign ld5    = !v5_reg || ld6;
    assign ld4    = !v4_reg || ld5;
    assign ld3    = !v3_reg || ld4;
    assign ld2    = !v2_reg || ld3;
    assign ld1    = !v1_reg || ld2;

    assign item.ready = ld1;
    assign accept     = item.valid && ld1;
    assign kind_ok    = (item.data.kind == KIND_LOAD) || (item.data.kind == KIND_FRAME) ||
                        (item.data.kind == KIND_PIXEL);

    // ------------------------------------------------------------------
    // Combinational work per stage
    // ------------------------------------------------------------------
    assign pix_prod1 = py1_reg * width_reg;
    assign pix_addr1 = pix_prod1[ADDR_W-1:0] + ADDR_W'(px1_reg);

    assign t1_ext  = SINE_IDX_W'(t1_reg);
    assign xa_sum1 = t1_ext + XA_OFS;
    assign c_sum1  = t1_ext + C_OFS;

    always_comb
    begin
        fidx1[TERM_XA] = {xa_sum1[7:0], 2'b00};
        fidx1[TERM_XB] = t1_ext + XB_OFS;
        fidx1[TERM_YA] = {t1_reg, 1'b0};
        fidx1[TERM_YB] = t1_ext + YB_OFS;
        fidx1[TERM_C]  = {c_sum1[6:0], 3'b000};
    end

    assign x_wave_next = 8'(term3_reg[TERM_XA]) + 8'(term3_reg[TERM_XB]);
    assign y_wave_next = 8'(term3_reg[TERM_YA]) + 8'(term3_reg[TERM_YB]);
    assign c_wave_next = term3_reg[TERM_C];

    // The low bit of the distance is dropped before it scales the c wave.
    assign cprod3 = signed'({1'b0, d3_reg[DIST_W-1:1]}) * c_wave_reg;

    assign i4 = {ihi4_reg, 1'b0};

    assign xprod5 = cos5_reg * xw5_reg;
    assign yprod5 = sin5_reg * yw5_reg;
    assign offx5  = xprod5[23:15];
    assign offy5  = yprod5[23:15];

    assign xlim6 = signed'({1'b0, width_reg} - 12'd2);
    assign ylim6 = signed'({2'b00, height_reg} - 12'd2);

    always_comb
    begin
        if (dx6_reg[11])
            sx6 = '0;
        else if (dx6_reg > xlim6)
            sx6 = PX_W'(xlim6);
        else
            sx6 = PX_W'(dx6_reg);

        if (dy6_reg[11])
            sy6 = '0;
        else if (dy6_reg > ylim6)
            sy6 = PY_W'(ylim6);
        else
            sy6 = PY_W'(dy6_reg);
    end

    assign out_prod7 = sy7_reg * width_reg;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            x_wave_reg    <= '0;
            y_wave_reg    <= '0;
            c_wave_reg    <= '0;
        end
        else
        begin
            if (ld1)
                v1_reg <= item.valid && kind_ok;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
            // Loads and frame starts are finished after stage 3.
            if (ld4)
                v4_reg <= v3_reg && (kind3_reg == KIND_PIXEL);
            if (ld5)
                v5_reg <= v4_reg;
            if (ld6)
                v6_reg <= v5_reg;
            if (ld7)
                v7_reg <= v6_reg;
            if (ld_out)
                out_valid_reg <= v7_reg;

            if (accept && item.data.kind == KIND_FRAME)
                phase_reg <= phase_reg + PY_W'(1);

            // Pixels latch the waves on this same move, so a pixel ahead of a
            // frame start keeps the old amplitudes and one behind sees the new.
            if (v3_reg && kind3_reg == KIND_FRAME && ld4)
            begin
                x_wave_reg <= x_wave_next;
                y_wave_reg <= y_wave_next;
                c_wave_reg <= c_wave_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance memory: at most one access per item as it moves from stage 2 to 3.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            if (kind2_reg == KIND_LOAD)
                dist_mem[addr2_reg] <= tval2_reg;
            if (kind2_reg == KIND_PIXEL)
                d3_reg <= dist_mem[addr2_reg];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            kind1_reg  <= item.data.kind;
            px1_reg    <= item.data.pixel_x;
            py1_reg    <= item.data.pixel_y;
            taddr1_reg <= item.data.table_address;
            tval1_reg  <= item.data.table_value;
            t1_reg     <= phase_reg;
        end

        if (ld2)
        begin
            kind2_reg <= kind1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            tval2_reg <= tval1_reg;
            addr2_reg <= (kind1_reg == KIND_PIXEL) ? pix_addr1 : taddr1_reg;
            for (int k = 0; k < FRAME_TERMS; k++)
            begin
                fold2_reg[k] <= sine_fold(fidx1[k]);
            end
        end

        if (ld3)
        begin
            kind3_reg          <= kind2_reg;
            px3_reg            <= px2_reg;
            py3_reg            <= py2_reg;
            term3_reg[TERM_XA] <= term_value(fold2_reg[TERM_XA], TERM_A30, 1'b0);
            term3_reg[TERM_XB] <= term_value(fold2_reg[TERM_XB], TERM_A40, 1'b0);
            term3_reg[TERM_YA] <= term_value(fold2_reg[TERM_YA], TERM_A35, 1'b1);
            term3_reg[TERM_YB] <= term_value(fold2_reg[TERM_YB], TERM_A40, 1'b0);
            term3_reg[TERM_C]  <= term_value(fold2_reg[TERM_C], TERM_A50, 1'b0);
        end

        if (ld4)
        begin
            px4_reg  <= px3_reg;
            py4_reg  <= py3_reg;
            ihi4_reg <= cprod3[12:4];
            xw4_reg  <= x_wave_reg;
            yw4_reg  <= y_wave_reg;
        end

        if (ld5)
        begin
            px5_reg  <= px4_reg;
            py5_reg  <= py4_reg;
            xw5_reg  <= xw4_reg;
            yw5_reg  <= yw4_reg;
            sin5_reg <= sine_value(i4);
            cos5_reg <= sine_value(i4 + COS_OFS);
        end

        if (ld6)
        begin
            dx6_reg <= signed'({2'b00, px5_reg}) + 12'(offx5);
            dy6_reg <= signed'({3'b000, py5_reg}) + 12'(offy5);
        end

        if (ld7)
        begin
            sx7_reg <= sx6;
            sy7_reg <= sy6;
        end

        if (ld_out)
        begin
            out_data_reg.src_x       <= sx7_reg;
            out_data_reg.src_y       <= sy7_reg;
            out_data_reg.src_address <= out_prod7[ADDR_W-1:0] + ADDR_W'(sx7_reg);
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ({1'b0, out_data_reg.src_x} <= width_reg - WIDTH_W'(2)) &&
            ({1'b0, out_data_reg.src_y} <= height_reg - HEIGHT_W'(2)))
        else $error("result lies outside the clamped frame");

    a_phase_step : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.data.kind == KIND_FRAME) |=> phase_reg == $past(phase_reg) + PY_W'(1))
        else $error("frame phase did not advance on a frame start");

    a_x_wave_range : assert property (@(posedge clk) disable iff (!rst_n)
        (x_wave_reg >= -8'sd70) && (x_wave_reg <= 8'sd70))
        else $error("x wave amplitude out of range");

    a_y_wave_range : assert property (@(posedge clk) disable iff (!rst_n)
        (y_wave_reg >= -8'sd75) && (y_wave_reg <= 8'sd75))
        else $error("y wave amplitude out of range");

    a_c_wave_range : assert property (@(posedge clk) disable iff (!rst_n)
        (c_wave_reg >= -7'sd50) && (c_wave_reg <= 7'sd50))
        else $error("c wave amplitude out of range");

endmodule
